/* sv/assert_macros.svh */
// assertion macros for the transform generator modules, used by htg_emit
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* sv/htg_pkg.sv */
// shared types, widths, opcodes and fixed-point constants of the transform generator
// no dependencies; imported by every module of the block
package htg_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int VAL_W         = 32;
    localparam int ANG_IN_W      = 19;
    localparam int ANG_W         = FRAC_BITS + 4;
    localparam int XY_W          = FRAC_BITS + 3;
    localparam int IDX_W         = 4;

    typedef logic [2:0] t_opcode;

    localparam t_opcode OP_IDENT = 3'd0;
    localparam t_opcode OP_ROTX  = 3'd1;
    localparam t_opcode OP_ROTY  = 3'd2;
    localparam t_opcode OP_ROTZ  = 3'd3;
    localparam t_opcode OP_TRANS = 3'd4;

    typedef struct packed {
        t_opcode                   opcode;
        logic                      neg;
        logic signed [VAL_W-1:0]   tx;
        logic signed [VAL_W-1:0]   ty;
        logic signed [VAL_W-1:0]   tz;
    } t_req;

    function automatic longint to_frac(longint q30);
        return (q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint atan_q30(int i);
        longint v;
        case (i)
            0:  v = 64'h3243F6A8;
            1:  v = 64'h1DAC6705;
            2:  v = 64'h0FADBAFC;
            3:  v = 64'h07F56EA6;
            4:  v = 64'h03FEAB76;
            5:  v = 64'h01FFD55B;
            6:  v = 64'h00FFFAAA;
            7:  v = 64'h007FFF55;
            8:  v = 64'h003FFFEA;
            9:  v = 64'h001FFFFD;
            10: v = 64'h000FFFFF;
            11: v = 64'h0007FFFF;
            12: v = 64'h0003FFFF;
            13: v = 64'h0001FFFF;
            14: v = 64'h0000FFFF;
            15: v = 64'h00007FFF;
            16: v = 64'h00003FFF;
            17: v = 64'h00001FFF;
            18: v = 64'h00000FFF;
            19: v = 64'h000007FF;
            20: v = 64'h000003FF;
            21: v = 64'h000001FF;
            22: v = 64'h000000FF;
            23: v = 64'h0000007F;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_fx(int i);
        return ANG_W'(to_frac(atan_q30(i)));
    endfunction

    localparam logic signed [ANG_W-1:0] PI_FX      = ANG_W'(to_frac(64'hC90FDAA2));
    localparam logic signed [ANG_W-1:0] NEG_PI_FX  = ANG_W'(-to_frac(64'hC90FDAA2));
    localparam logic signed [ANG_W-1:0] HPI_FX     = ANG_W'(to_frac(64'h6487ED51));
    localparam logic signed [ANG_W-1:0] NEG_HPI_FX = ANG_W'(-to_frac(64'h6487ED51));
    localparam logic signed [XY_W-1:0]  KINV_FX    = XY_W'(to_frac(64'h26DD3B6A));
    localparam logic signed [VAL_W-1:0] ONE_FX     = VAL_W'(64'sd1 <<< FRAC_BITS);

endpackage

/* sv/htg_fold.sv */
// angle clamp and quadrant fold, first register stage of the pipeline
// depends on htg_pkg
module htg_fold
    import htg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  t_opcode                    i_opcode,
    input  logic signed [ANG_IN_W-1:0] i_angle,
    input  logic signed [VAL_W-1:0]    i_tx,
    input  logic signed [VAL_W-1:0]    i_ty,
    input  logic signed [VAL_W-1:0]    i_tz,
    output logic                       o_valid,
    output logic signed [ANG_W-1:0]    o_z,
    output t_req                       o_req
);

    logic                    r_valid;
    logic signed [ANG_W-1:0] r_z;
    t_req                    r_req;
    logic signed [ANG_W-1:0] ang_ext;
    logic signed [ANG_W-1:0] ang_clamp;
    logic signed [ANG_W-1:0] n_z;
    logic                    n_neg;

    assign ang_ext = ANG_W'(i_angle);

    always_comb begin
        if (ang_ext > PI_FX) begin
            ang_clamp = PI_FX;
        end else if (ang_ext < NEG_PI_FX) begin
            ang_clamp = NEG_PI_FX;
        end else begin
            ang_clamp = ang_ext;
        end
        if (ang_clamp > HPI_FX) begin
            n_z   = ang_clamp - PI_FX;
            n_neg = 1'b1;
        end else if (ang_clamp < NEG_HPI_FX) begin
            n_z   = ang_clamp + PI_FX;
            n_neg = 1'b1;
        end else begin
            n_z   = ang_clamp;
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z          <= n_z;
            r_req.opcode <= i_opcode;
            r_req.neg    <= n_neg;
            r_req.tx     <= i_tx;
            r_req.ty     <= i_ty;
            r_req.tz     <= i_tz;
        end
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_req   = r_req;

endmodule

/* sv/htg_cordic.sv */
// pipelined rotation-mode cordic, one micro-rotation per register stage
// depends on htg_pkg
module htg_cordic
    import htg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_z,
    input  t_req                    i_req,
    output logic                    o_valid,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [XY_W-1:0]  o_y,
    output t_req                    o_req
);

    logic                    r_v [CORDIC_STAGES];
    logic signed [XY_W-1:0]  r_x [CORDIC_STAGES];
    logic signed [XY_W-1:0]  r_y [CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_z [CORDIC_STAGES];
    t_req                    r_req [CORDIC_STAGES];

    genvar g;
    for (g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam logic signed [ANG_W-1:0] ATAN = atan_fx(g);
        logic                    v_in;
        logic signed [XY_W-1:0]  x_in;
        logic signed [XY_W-1:0]  y_in;
        logic signed [ANG_W-1:0] z_in;
        t_req                    req_in;
        logic signed [XY_W-1:0]  n_x;
        logic signed [XY_W-1:0]  n_y;
        logic signed [ANG_W-1:0] n_z;

        if (g == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = KINV_FX;
            assign y_in   = '0;
            assign z_in   = i_z;
            assign req_in = i_req;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign x_in   = r_x[g-1];
            assign y_in   = r_y[g-1];
            assign z_in   = r_z[g-1];
            assign req_in = r_req[g-1];
        end

        always_comb begin
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - ATAN;
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]   <= n_x;
                r_y[g]   <= n_y;
                r_z[g]   <= n_z;
                r_req[g] <= req_in;
            end
        end
    end

    assign o_valid = r_v[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_y     = r_y[CORDIC_STAGES-1];
    assign o_req   = r_req[CORDIC_STAGES-1];

endmodule

/* sv/htg_emit.sv */
// matrix slot and entry serializer with registered output stage
// depends on htg_pkg and assert_macros.svh
`include "assert_macros.svh"
module htg_emit
    import htg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  t_req                    i_req,
    output logic                    o_ready,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [1:0]              o_row,
    output logic [1:0]              o_col,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = '1;

    logic                    r_busy;
    logic [IDX_W-1:0]        r_cnt;
    t_req                    r_req;
    logic signed [VAL_W-1:0] r_cos;
    logic signed [VAL_W-1:0] r_sin;
    logic signed [VAL_W-1:0] r_nsin;
    logic                    r_o_valid;
    logic [1:0]              r_o_row;
    logic [1:0]              r_o_col;
    logic signed [VAL_W-1:0] r_o_value;
    logic                    r_o_last;

    logic                    take;
    logic                    out_load;
    logic signed [VAL_W-1:0] x_ext;
    logic signed [VAL_W-1:0] y_ext;
    logic signed [VAL_W-1:0] n_cos;
    logic signed [VAL_W-1:0] n_sin;
    logic signed [VAL_W-1:0] ident;
    logic signed [VAL_W-1:0] sel;

    assign out_load = r_busy && (!r_o_valid || !i_stall);
    assign o_ready  = !r_busy || (out_load && (r_cnt == LAST_IDX));
    assign take     = i_valid && o_ready;

    assign x_ext = VAL_W'(i_x);
    assign y_ext = VAL_W'(i_y);
    assign n_cos = i_req.neg ? -x_ext : x_ext;
    assign n_sin = i_req.neg ? -y_ext : y_ext;

    always_comb begin
        if (r_cnt == 4'd0 || r_cnt == 4'd5 || r_cnt == 4'd10 || r_cnt == 4'd15) begin
            ident = ONE_FX;
        end else begin
            ident = '0;
        end
        case (r_req.opcode)
            OP_ROTX: begin
                case (r_cnt)
                    4'd5, 4'd10: sel = r_cos;
                    4'd6:        sel = r_nsin;
                    4'd9:        sel = r_sin;
                    default:     sel = ident;
                endcase
            end
            OP_ROTY: begin
                case (r_cnt)
                    4'd0, 4'd10: sel = r_cos;
                    4'd2:        sel = r_sin;
                    4'd8:        sel = r_nsin;
                    default:     sel = ident;
                endcase
            end
            OP_ROTZ: begin
                case (r_cnt)
                    4'd0, 4'd5: sel = r_cos;
                    4'd1:       sel = r_nsin;
                    4'd4:       sel = r_sin;
                    default:    sel = ident;
                endcase
            end
            OP_TRANS: begin
                case (r_cnt)
                    4'd3:    sel = r_req.tx;
                    4'd7:    sel = r_req.ty;
                    4'd11:   sel = r_req.tz;
                    default: sel = ident;
                endcase
            end
            default: sel = ident;
        endcase
    end

    // slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (out_load) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req  <= i_req;
            r_cos  <= n_cos;
            r_sin  <= n_sin;
            r_nsin <= -n_sin;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_row   <= r_cnt[3:2];
            r_o_col   <= r_cnt[1:0];
            r_o_value <= sel;
            r_o_last  <= (r_cnt == LAST_IDX);
        end
    end

    assign o_valid = r_o_valid;
    assign o_row   = r_o_row;
    assign o_col   = r_o_col;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;

    `ASSERT_PROP(a_last_pos, i_clk, i_rst_n, r_o_valid && r_o_last |-> r_o_row == 2'd3 && r_o_col == 2'd3, "last flag off the final entry")
    `ASSERT_NEVER(a_slot_held, i_clk, i_rst_n, r_o_valid && !r_o_last && !r_busy, "slot freed before final entry")
    `ASSERT_PROP(a_take_start, i_clk, i_rst_n, take |=> r_busy && r_cnt == 4'd0, "new request did not restart the entry count")

endmodule

/* sv/homogeneous_transform_generator.sv */
// top level of the 4x4 homogeneous transform generator
// depends on htg_pkg, htg_fold, htg_cordic and htg_emit
//
// usage
// input channel: i_valid / o_stall with i_opcode, i_angle, i_tx, i_ty, i_tz.
//   a request is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with o_row, o_col, o_value, o_last.
//   sixteen entries per request in row-major order, o_last on row 3 col 3.
// first entry path: fold register, cordic stage registers, emit slot, output
//   register; after it, one entry per cycle while i_stall is low.
// the sustained request rate is set by the single emit slot, which serializes
//   sixteen entries per request; the fold stage and the cordic pipeline hold
//   up to CORDIC_STAGES + 1 more requests, and a new request enters while the
//   previous matrix is still streaming out.
// reset (i_rst_n low, synchronous) empties every stage and the output.
// when the receiver stalls, the output entry holds; once the cordic
//   pipeline's last stage has nowhere to go, all stages freeze and o_stall rises.
module homogeneous_transform_generator
    import htg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  t_opcode                    i_opcode,
    input  logic signed [ANG_IN_W-1:0] i_angle,
    input  logic signed [VAL_W-1:0]    i_tx,
    input  logic signed [VAL_W-1:0]    i_ty,
    input  logic signed [VAL_W-1:0]    i_tz,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_row,
    output logic [1:0]                 o_col,
    output logic signed [VAL_W-1:0]    o_value,
    output logic                       o_last
);

    logic                    pipe_en;
    logic                    fold_valid;
    logic signed [ANG_W-1:0] fold_z;
    t_req                    fold_req;
    logic                    cor_valid;
    logic signed [XY_W-1:0]  cor_x;
    logic signed [XY_W-1:0]  cor_y;
    t_req                    cor_req;
    logic                    emit_ready;

    assign pipe_en = !cor_valid || emit_ready;
    assign o_stall = !pipe_en;

    htg_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_angle  (i_angle),
        .i_tx     (i_tx),
        .i_ty     (i_ty),
        .i_tz     (i_tz),
        .o_valid  (fold_valid),
        .o_z      (fold_z),
        .o_req    (fold_req)
    );

    htg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (fold_valid),
        .i_z     (fold_z),
        .i_req   (fold_req),
        .o_valid (cor_valid),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_req   (cor_req)
    );

    htg_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cor_valid),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .i_req   (cor_req),
        .o_ready (emit_ready),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_row   (o_row),
        .o_col   (o_col),
        .o_value (o_value),
        .o_last  (o_last)
    );

endmodule
